// File: hdl/bpp_pkg.sv
// Shared types, constants and pattern ROM for the buzzer pattern player.
package bpp_pkg;

    localparam int SLOTS_PER_MESSAGE = 10;
    localparam int MESSAGE_COUNT     = 7;

    localparam int ROM_ROWS = 7;
    localparam int ROM_COLS = 10;

    localparam int KIND_W = 2;
    localparam int MSG_W  = 3;
    localparam int SLOT_W = 4;
    localparam int DUR_W  = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_SELECT = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } bpp_kind_t;

    typedef struct packed {
        logic [DUR_W-1:0]  remaining_ms;
        logic [SLOT_W-1:0] slot_counter;
        logic [MSG_W-1:0]  active_message;
        logic              buzzer_level;
    } bpp_state_t;

    localparam logic [DUR_W-1:0] PATTERN_ROM [ROM_ROWS][ROM_COLS] = '{
        '{11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
          11'd0,    11'd0,    11'd0,    11'd0,    11'd0},
        '{11'd500,  11'd500,  11'd500,  11'd500,  11'd0,
          11'd0,    11'd0,    11'd0,    11'd0,    11'd0},
        '{11'd2000, 11'd500,  11'd500,  11'd500,  11'd500,
          11'd500,  11'd0,    11'd0,    11'd0,    11'd0},
        '{11'd50,   11'd100,  11'd50,   11'd1000, 11'd50,
          11'd100,  11'd50,   11'd1000, 11'd0,    11'd0},
        '{11'd100,  11'd500,  11'd100,  11'd500,  11'd100,
          11'd500,  11'd0,    11'd0,    11'd0,    11'd0},
        '{11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000,
          11'd1000, 11'd1000, 11'd1000, 11'd1000, 11'd1000},
        '{11'd50,   11'd100,  11'd50,   11'd100,  11'd0,
          11'd0,    11'd0,    11'd0,    11'd0,    11'd0}
    };

    function automatic logic [DUR_W-1:0] rom_duration(
        input logic [MSG_W-1:0]  msg,
        input logic [SLOT_W-1:0] slot
    );
        logic [DUR_W-1:0] dur;
        dur = '0;
        if ({1'b0, msg} < (MSG_W+1)'(ROM_ROWS) && {1'b0, slot} < (SLOT_W+1)'(ROM_COLS))
        begin
            dur = PATTERN_ROM[msg][slot];
        end
        return dur;
    endfunction

endpackage

// File: hdl/bpp_step.sv
// Next-state logic for one beat: tick countdown, slot advance, select and clear.
module bpp_step
    import bpp_pkg::*;
(
    input  logic [KIND_W-1:0] kind,
    input  logic [MSG_W-1:0]  message,
    input  bpp_state_t        cur,
    output bpp_state_t        nxt
);

    logic [DUR_W-1:0] rem_dec;

    assign rem_dec = (cur.remaining_ms != '0) ? cur.remaining_ms - DUR_W'(1) : '0;

    always_comb
    begin
        nxt = cur;
        case (bpp_kind_t'(kind))
            KIND_TICK:
            begin
                nxt.remaining_ms = rem_dec;
                if (cur.active_message != '0 && rem_dec == '0)
                begin
                    if ({1'b0, cur.slot_counter} >= (SLOT_W+1)'(SLOTS_PER_MESSAGE))
                    begin
                        nxt.slot_counter   = '0;
                        nxt.active_message = '0;
                    end
                    else
                    begin
                        nxt.buzzer_level = ~cur.slot_counter[0];
                        nxt.remaining_ms = rom_duration(cur.active_message,
                                                        cur.slot_counter);
                        nxt.slot_counter = cur.slot_counter + SLOT_W'(1);
                    end
                end
            end
            KIND_SELECT:
            begin
                if ({1'b0, message} < (MSG_W+1)'(MESSAGE_COUNT))
                begin
                    nxt.active_message = message;
                end
            end
            KIND_CLEAR:
            begin
                nxt.slot_counter   = '0;
                nxt.active_message = '0;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: hdl/buzzer_pattern_player.sv
// Top level of the buzzer pattern player: input register, state and result register.
//
// Usage:
//   Input channel (item_valid / item_stall) carries one beat per item: kind
//   (tick, select, clear) and message. Output channel (result_valid /
//   result_stall) returns exactly one beat per item with buzzer_on, playing
//   and slot_index as they stand after that item.
//   Path: an accepted beat lands in the input register; from there the state
//   update writes the state register and the result register together,
//   which then show the result for that item.
//   Throughput: one item per cycle while no result is held under
//   result_stall; the state update is a single compare, decrement and ROM
//   lookup between the input register and the result register.
//   Reset: countdown, slot index, message and buzzer level clear to zero;
//   both pipeline stages empty.
//   Stall: while result_stall holds a waiting result, one more item is still
//   taken into the input register; item_stall rises only when both the input
//   register and the result register are full.
module buzzer_pattern_player
    import bpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [MSG_W-1:0]  message,
    output logic              result_valid,
    input  logic              result_stall,
    output logic              buzzer_on,
    output logic              playing,
    output logic [SLOT_W-1:0] slot_index
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [KIND_W-1:0] s1_kind_reg;
    logic [MSG_W-1:0]  s1_message_reg;
    bpp_state_t        state_reg;
    bpp_state_t        state_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    logic              buzzer_on_reg;
    logic              playing_reg;
    logic [SLOT_W-1:0] slot_index_reg;
    logic              s2_ready;
    logic              s1_advance;
    logic              item_take;

    assign s2_ready   = !result_valid_reg || !result_stall;
    assign s1_advance = s1_valid_reg && s2_ready;
    assign item_stall = s1_valid_reg && !s2_ready;
    assign item_take  = item_valid && !item_stall;

    assign s1_valid_next     = item_stall ? s1_valid_reg : item_valid;
    assign result_valid_next = s2_ready ? s1_valid_reg : result_valid_reg;

    bpp_step u_step (
        .kind    (s1_kind_reg),
        .message (s1_message_reg),
        .cur     (state_reg),
        .nxt     (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_kind_reg    <= kind;
            s1_message_reg <= message;
        end
        if (s1_advance)
        begin
            buzzer_on_reg  <= state_next.buzzer_level;
            playing_reg    <= (state_next.active_message != '0);
            slot_index_reg <= state_next.slot_counter;
        end
    end

    assign result_valid = result_valid_reg;
    assign buzzer_on    = buzzer_on_reg;
    assign playing      = playing_reg;
    assign slot_index   = slot_index_reg;

endmodule

// File: hdl/bpp_checker.sv
// Port-level assertions for the buzzer pattern player, bound to the top level.
module bpp_checker
    import bpp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input logic              buzzer_on,
    input logic              playing,
    input logic [SLOT_W-1:0] slot_index
);

    // input side only backs up when a result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item_stall without a held result");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, slot_index} <= (SLOT_W+1)'(SLOTS_PER_MESSAGE)))
        else $error("slot_index past end of message");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result beat dropped under stall");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            ($stable(buzzer_on) && $stable(playing) && $stable(slot_index)))
        else $error("result payload changed under stall");

endmodule

bind buzzer_pattern_player bpp_checker u_bpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .buzzer_on    (buzzer_on),
    .playing      (playing),
    .slot_index   (slot_index)
);
